>>> src/qnec_pkg.sv
// quoted newline escape codec: shared types, byte constants and token helpers
// no dependencies; imported by every module of the block
`default_nettype none

package qnec_pkg;

   localparam int unsigned MAX_TOKEN_BYTES = 8;

   localparam logic [7:0] LT_BYTE = 8'h3C;
   localparam logic [7:0] GT_BYTE = 8'h3E;
   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [7:0] LF_BYTE = 8'h0A;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef enum logic [2:0] {
      CSR_CR_TOKEN_BYTES  = 3'd0,
      CSR_CR_TOKEN_LENGTH = 3'd1,
      CSR_LF_TOKEN_BYTES  = 3'd2,
      CSR_LF_TOKEN_LENGTH = 3'd3,
      CSR_QUOTE_BYTE      = 3'd4,
      CSR_ESCAPE_ENABLE   = 3'd5,
      CSR_UNESCAPE_ENABLE = 3'd6,
      CSR_IGNORE_QUOTES   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
      logic       stream_done;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic [63:0] cr_token_bytes;
      logic [3:0]  cr_token_length;
      logic [63:0] lf_token_bytes;
      logic [3:0]  lf_token_length;
      logic [7:0]  quote_byte;
      logic        escape_enable;
      logic        unescape_enable;
      logic        ignore_quotes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cr_token_bytes:  64'h0000_0000_3E52_433C,
      cr_token_length: 4'd4,
      lf_token_bytes:  64'h0000_0000_3E46_4C3C,
      lf_token_length: 4'd4,
      quote_byte:      8'h22,
      escape_enable:   1'b0,
      unescape_enable: 1'b0,
      ignore_quotes:   1'b0
   };

   // one entry per input item: [pre byte] [tok_n token bytes] [post byte],
   // or a single result without a byte
   typedef struct packed {
      logic        pre_en;
      logic [7:0]  pre_byte;
      logic [63:0] tok;
      logic [3:0]  tok_n;
      logic        post_en;
      logic [7:0]  post_byte;
      logic        no_byte;
      logic        err;
      logic        eos;
   } desc_type;

   function automatic logic [3:0] clamp_len(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      if (v > 4'(MAX_TOKEN_BYTES)) r = 4'(MAX_TOKEN_BYTES);
      return r;
   endfunction

   function automatic logic [7:0] tok_at(input logic [63:0] tok, input logic [2:0] i);
      return tok[{i, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

>>> src/qnec_front.sv
// front part: quote tracking, escape and decode matching, one item per accepted cycle
// depends on qnec_pkg; emits one descriptor per item that has results
`default_nettype none

module qnec_front
   import qnec_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire req_type  req_data,
   input  wire cfg_type  cfg,
   output logic          desc_push,
   output desc_type      desc
);

   logic       inq_ff, inq_in;
   logic       run_ff, run_in;
   logic       dec_ff, dec_in;
   logic [2:0] pos_ff, pos_in;
   logic       crp_ff, crp_in;
   logic       lfp_ff, lfp_in;
   logic       one_ff, one_in;
   logic       err_ff, err_in;

   logic [7:0] b;
   logic       active;
   logic [3:0] crl, lfl, pos_next;
   logic       cr_m, lf_m, cr_done, lf_done, fail_cr, fail_lf;

   assign b        = req_data.in_byte;
   assign active   = inq_ff | cfg.ignore_quotes;
   assign crl      = clamp_len(cfg.cr_token_length);
   assign lfl      = clamp_len(cfg.lf_token_length);
   assign pos_next = {1'b0, pos_ff} + 4'd1;

   assign cr_m    = ({1'b0, pos_ff} < crl) && (tok_at(cfg.cr_token_bytes, pos_ff) == b);
   assign lf_m    = ({1'b0, pos_ff} < lfl) && (tok_at(cfg.lf_token_bytes, pos_ff) == b);
   assign cr_done = crp_ff & cr_m & (pos_next == crl);
   assign fail_cr = crp_ff & ~cr_m & ~lfp_ff;
   assign lf_done = lfp_ff & lf_m & (pos_next == lfl);
   assign fail_lf = lfp_ff & ~lf_m & ~(crp_ff & cr_m);

   always_comb begin
      inq_in = inq_ff;
      run_in = run_ff;
      dec_in = dec_ff;
      pos_in = pos_ff;
      crp_in = crp_ff;
      lfp_in = lfp_ff;
      one_in = one_ff;
      err_in = err_ff;
      desc   = '0;

      if (req_data.kind == KIND_EOS) begin
         if (dec_ff) begin
            desc.no_byte = 1'b1;
         end else if (run_ff && !err_ff) begin
            desc.post_en   = 1'b1;
            desc.post_byte = GT_BYTE;
         end else begin
            desc.no_byte = 1'b1;
         end
         desc.err = err_ff | dec_ff;
         desc.eos = 1'b1;
         // stream state back to reset
         inq_in = 1'b0;
         run_in = 1'b0;
         dec_in = 1'b0;
         pos_in = 3'd0;
         crp_in = 1'b1;
         lfp_in = 1'b1;
         one_in = 1'b0;
         err_in = 1'b0;
      end else if (err_ff) begin
         desc.no_byte = 1'b1;
         desc.err     = 1'b1;
      end else begin
         if (dec_ff) begin
            if (b == GT_BYTE && one_ff && pos_ff == 3'd0) begin
               dec_in = 1'b0;
               pos_in = 3'd0;
               crp_in = 1'b1;
               lfp_in = 1'b1;
               one_in = 1'b0;
            end else if (cr_done || (!fail_cr && !fail_lf && lf_done)) begin
               desc.post_en   = 1'b1;
               desc.post_byte = cr_done ? CR_BYTE : LF_BYTE;
               pos_in = 3'd0;
               crp_in = 1'b1;
               lfp_in = 1'b1;
               one_in = 1'b1;
            end else if (fail_cr || fail_lf) begin
               if (one_ff) begin
                  err_in       = 1'b1;
                  desc.no_byte = 1'b1;
               end else begin
                  desc.pre_en    = 1'b1;
                  desc.pre_byte  = LT_BYTE;
                  desc.tok       = fail_cr ? cfg.cr_token_bytes : cfg.lf_token_bytes;
                  desc.tok_n     = {1'b0, pos_ff};
                  desc.post_en   = 1'b1;
                  desc.post_byte = b;
               end
               dec_in = 1'b0;
               pos_in = 3'd0;
               crp_in = 1'b1;
               lfp_in = 1'b1;
               one_in = 1'b0;
            end else begin
               crp_in = crp_ff & cr_m;
               lfp_in = lfp_ff & lf_m;
               pos_in = pos_next[2:0];
            end
         end else if (b == LT_BYTE) begin
            desc.pre_en   = run_ff;
            desc.pre_byte = GT_BYTE;
            run_in        = 1'b0;
            if (active && cfg.unescape_enable) begin
               dec_in = 1'b1;
               pos_in = 3'd0;
               crp_in = 1'b1;
               lfp_in = 1'b1;
               one_in = 1'b0;
            end else begin
               desc.post_en   = 1'b1;
               desc.post_byte = LT_BYTE;
            end
         end else if (b == CR_BYTE || b == LF_BYTE) begin
            if (active && cfg.escape_enable) begin
               desc.pre_en   = ~run_ff;
               desc.pre_byte = LT_BYTE;
               run_in        = 1'b1;
               desc.tok      = (b == LF_BYTE) ? cfg.lf_token_bytes : cfg.cr_token_bytes;
               desc.tok_n    = (b == LF_BYTE) ? lfl : crl;
            end else begin
               desc.post_en   = 1'b1;
               desc.post_byte = b;
            end
         end else begin
            desc.pre_en    = run_ff;
            desc.pre_byte  = GT_BYTE;
            run_in         = 1'b0;
            if (b == cfg.quote_byte) inq_in = ~inq_ff;
            desc.post_en   = 1'b1;
            desc.post_byte = b;
         end
         desc.err = err_in;
      end
   end

   assign desc_push = accept &
                      (desc.pre_en | desc.post_en | desc.no_byte | (desc.tok_n != 4'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff <= 1'b0;
         run_ff <= 1'b0;
         dec_ff <= 1'b0;
         pos_ff <= 3'd0;
         crp_ff <= 1'b1;
         lfp_ff <= 1'b1;
         one_ff <= 1'b0;
         err_ff <= 1'b0;
      end else if (accept) begin
         inq_ff <= inq_in;
         run_ff <= run_in;
         dec_ff <= dec_in;
         pos_ff <= pos_in;
         crp_ff <= crp_in;
         lfp_ff <= lfp_in;
         one_ff <= one_in;
         err_ff <= err_in;
      end
   end

endmodule

`default_nettype wire

>>> src/qnec_queue.sv
// short descriptor queue between front and back parts
// depends on qnec_pkg for the descriptor type
`default_nettype none

module qnec_queue
   import qnec_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_en,
   input  wire desc_type wr_data,
   input  wire logic     rd_en,
   output logic          full,
   output logic          rd_valid,
   output desc_type      rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      if (!wr_en && rd_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

`default_nettype wire

>>> src/qnec_back.sv
// back part: expands one descriptor into result beats, one beat per cycle while the output register is empty or popped
// depends on qnec_pkg; holds the registered result beat
`default_nettype none

module qnec_back
   import qnec_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire desc_type q_head,
   input  wire logic     pop,
   output logic          q_pop,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   logic [3:0] beat_ff, beat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [3:0] len, t;
   logic       advance, is_last;

   assign len     = q_head.no_byte ? 4'd1
                    : 4'({3'b000, q_head.pre_en}) + q_head.tok_n + {3'b000, q_head.post_en};
   assign t       = beat_ff - {3'b000, q_head.pre_en};
   assign is_last = (beat_ff == len - 4'd1);
   assign advance = q_valid & (~rsp_valid_ff | pop);
   assign q_pop   = advance & is_last;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      if (pop) rsp_valid_in = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         beat_in      = is_last ? 4'd0 : beat_ff + 4'd1;
         rsp_in.has_byte    = ~q_head.no_byte;
         rsp_in.last        = is_last;
         rsp_in.stream_done = is_last & q_head.eos;
         rsp_in.error       = q_head.err;
         if (q_head.no_byte) begin
            rsp_in.out_byte = 8'd0;
         end else if (q_head.pre_en && beat_ff == 4'd0) begin
            rsp_in.out_byte = q_head.pre_byte;
         end else if (t < q_head.tok_n) begin
            rsp_in.out_byte = tok_at(q_head.tok, t[2:0]);
         end else begin
            rsp_in.out_byte = q_head.post_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> src/quoted_newline_escape_codec.sv
// top level of the quoted newline escape codec: config registers and wiring
// depends on qnec_pkg, qnec_front, qnec_queue and qnec_back
`default_nettype none

// The codec takes one stream beat per cycle (data byte or end of stream) and
// writes result beats to a queue-style output. Inside quoted sections, or
// everywhere with ignore_quotes, raw CR/LF runs can be written as '<' plus
// token bytes plus a closing '>', and such token runs can be decoded back.
// The front stage classifies and matches each input beat combinationally
// and hands a descriptor to a QUEUE_DEPTH-entry queue; the back stage turns
// each descriptor into 1 to 9 result beats at one beat per cycle while they
// are popped. Input beats that make no result (bytes taken into a decode)
// write no descriptor. Input accepts one beat per cycle as long as the queue
// has room, so the sustained rate, while results are popped, is one result
// beat per cycle, set by the back stage's single output register: an input
// beat that makes n results occupies the back stage for n result beats, and
// one that makes none costs it nothing. With the queue and the output
// register empty, the first result beat goes through the queue and then the
// output register to the result ports. Configuration writes are always taken
// (ready is tied high) and must only happen while idle.

module quoted_newline_escape_codec
   import qnec_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   // input beats
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,

   // result beats
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,

   // register writes
   input  wire logic        valid,
   output logic             ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     accept;
   logic     q_push, q_full, q_valid, q_pop;
   desc_type q_wr_data, q_head;
   logic     rsp_valid;

   // register file; tied ready, writes land at once
   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_index_type'(csr_index))
            CSR_CR_TOKEN_BYTES:  cfg_in.cr_token_bytes  = csr_wdata;
            CSR_CR_TOKEN_LENGTH: cfg_in.cr_token_length = csr_wdata[3:0];
            CSR_LF_TOKEN_BYTES:  cfg_in.lf_token_bytes  = csr_wdata;
            CSR_LF_TOKEN_LENGTH: cfg_in.lf_token_length = csr_wdata[3:0];
            CSR_QUOTE_BYTE:      cfg_in.quote_byte      = csr_wdata[7:0];
            CSR_ESCAPE_ENABLE:   cfg_in.escape_enable   = csr_wdata[0];
            CSR_UNESCAPE_ENABLE: cfg_in.unescape_enable = csr_wdata[0];
            CSR_IGNORE_QUOTES:   cfg_in.ignore_quotes   = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side stalls only on a full descriptor queue
   assign full   = q_full;
   assign accept = push & ~q_full;

   qnec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .desc_push (q_push),
      .desc      (q_wr_data)
   );

   qnec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_data),
      .rd_en    (q_pop),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_data  (q_head)
   );

   // back stage expands descriptors into beats behind the output register
   qnec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop & ~empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign empty = ~rsp_valid;

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("descriptor written into full queue");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.stream_done) |-> rsp_data.last)
      else $error("stream done beat is not the last beat of its item");

   a_no_byte_alone: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.has_byte) |-> rsp_data.last)
      else $error("beat without byte is not the only beat of its item");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result beat present right after reset");
`endif

endmodule

`default_nettype wire
